/* rtl/core/sef_pkg.sv */
package sef_pkg;

  // Channels per pixel: red, green, blue, alpha from the lowest bits up
  localparam int NUM_CH = 4;

  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 12;
  localparam int CFG_DATA_W   = 12;
  localparam int ROW_W        = 12;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 12'd480;

  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  // Result control that travels with one window shift
  typedef struct packed {
    logic emit;
    logic col_lo_ok;
    logic col_hi_ok;
    logic row_lo_ok;
    logic row_hi_ok;
    logic last;
  } win_ctrl_t;

endpackage

/* rtl/core/sef_line_mem.sv */
module sef_line_mem
  import sef_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int AW = 10,
  parameter int DW = 64
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/core/sef_window.sv */
module sef_window
  import sef_pkg::*;
#(
  parameter int CHANNEL_BITS = 8,
  localparam int PixW = NUM_CH * CHANNEL_BITS,
  localparam int EdgeW = CHANNEL_BITS + 3,
  localparam int ResW = NUM_CH * EdgeW
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            shift,
  input  logic [PixW-1:0] col_top,
  input  logic [PixW-1:0] col_mid,
  input  logic [PixW-1:0] col_new,
  input  win_ctrl_t       ctrl,
  output logic            res_valid,
  output logic [ResW-1:0] res_edges,
  output logic            res_last
);

  localparam int SumW = CHANNEL_BITS + 2;

  logic [PixW-1:0] win [9];
  win_ctrl_t ctrl_q;
  logic valid_q;

  logic row_ok [3];
  logic col_ok [3];
  logic [CHANNEL_BITS-1:0] smp [NUM_CH][9];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) begin
        win[i] <= '0;
      end
      valid_q <= 1'b0;
    end else begin
      valid_q <= shift && ctrl.emit;
      if (shift) begin
        // advance each row one column left, new column on the right
        for (int i = 0; i < 3; i++) begin
          win[i*3]     <= win[i*3+1];
          win[i*3 + 1] <= win[i*3+2];
        end
        win[2] <= col_top;
        win[5] <= col_mid;
        win[8] <= col_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      ctrl_q <= ctrl;
    end
  end

  always_comb begin
    row_ok[0] = ctrl_q.row_lo_ok;
    row_ok[1] = 1'b1;
    row_ok[2] = ctrl_q.row_hi_ok;
    col_ok[0] = ctrl_q.col_lo_ok;
    col_ok[1] = 1'b1;
    col_ok[2] = ctrl_q.col_hi_ok;
  end

  // zero the neighbors that fall outside the image
  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          smp[k][i*3+j] = win[i*3+j][k*CHANNEL_BITS +: CHANNEL_BITS]
                          & {CHANNEL_BITS{row_ok[i] && col_ok[j]}};
        end
      end
    end
  end

  always_comb begin
    logic [SumW-1:0] left, right, up, down, abs_x, abs_y;
    for (int k = 0; k < NUM_CH; k++) begin
      left  = SumW'(smp[k][0]) + SumW'({smp[k][3], 1'b0}) + SumW'(smp[k][6]);
      right = SumW'(smp[k][2]) + SumW'({smp[k][5], 1'b0}) + SumW'(smp[k][8]);
      up    = SumW'(smp[k][0]) + SumW'({smp[k][1], 1'b0}) + SumW'(smp[k][2]);
      down  = SumW'(smp[k][6]) + SumW'({smp[k][7], 1'b0}) + SumW'(smp[k][8]);
      abs_x = (right >= left) ? right - left : left - right;
      abs_y = (down >= up) ? down - up : up - down;
      res_edges[k*EdgeW +: EdgeW] = EdgeW'(abs_x) + EdgeW'(abs_y);
    end
  end

  assign res_valid = valid_q;
  assign res_last  = ctrl_q.last;

endmodule

/* rtl/core/sef_out_fifo.sv */
module sef_out_fifo
  import sef_pkg::*;
#(
  parameter int DEPTH = 4,
  parameter int DW = 45,
  localparam int CntW = $clog2(DEPTH + 1)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [DW-1:0]   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [DW-1:0]   out_data,
  output logic [CntW-1:0] count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DW-1:0] mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CntW-1:0] count_q;
  logic pop;

  assign pop = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      count_q <= '0;
    end else begin
      if (in_valid) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({in_valid, pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      mem[wr_ptr] <= in_data;
    end
  end

  assign out_valid = (count_q != '0);
  assign out_data  = mem[rd_ptr];
  assign count     = count_q;

endmodule

/* rtl/core/sobel_edge_filter_core.sv */
// Path: a pixel's result beat passes the read stage, window registers and output queue
//   to m_tvalid after the beat that completes its neighborhood (image_width+1 beats later).
// Throughput: one input beat per clock while s_tready is high; the line-buffer RAM does one
//   read and one write per clock, with same-column reads of back-to-back beats forwarded.
// Reset: counters, window and output queue clear, width/height return to 640/480;
//   line-buffer contents are left as they are and never read unmasked.
module sobel_edge_filter_core
  import sef_pkg::*;
#(
  parameter int MAX_WIDTH = 1024,
  parameter int CHANNEL_BITS = 8,
  localparam int InDataW = ((NUM_CH * CHANNEL_BITS + 7) / 8) * 8,
  localparam int OutDataW = ((NUM_CH * (CHANNEL_BITS + 3) + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // in_red, in_green, in_blue, in_alpha
  input  logic [InDataW-1:0]    s_tdata,
  // action
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // edge_red, edge_green, edge_blue, edge_alpha
  output logic [OutDataW-1:0]   m_tdata,
  output logic                  m_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  cfg_reg_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int CmpW = (WW > WIDTH_REG_W) ? WW : WIDTH_REG_W;
  localparam int RowW = ROW_W + 1;
  localparam int PixW = NUM_CH * CHANNEL_BITS;
  localparam int EdgeW = CHANNEL_BITS + 3;
  localparam int ResW = NUM_CH * EdgeW;
  localparam int FifoDepth = 4;
  localparam int FifoCntW = $clog2(FifoDepth + 1);
  localparam int CrW = FifoCntW + 1;

  logic [WIDTH_REG_W-1:0]  reg_width;
  logic [HEIGHT_REG_W-1:0] reg_height;
  logic [WW-1:0]    w_eff;
  logic [ROW_W-1:0] h_eff;
  logic [CmpW-1:0]  width_ext;

  logic [CW-1:0]    col_cnt, col_next, col_a;
  logic [ROW_W-1:0] row_cnt, row_next, row_a;
  logic [WW-1:0]    flush_cnt, flush_next;
  logic [WW-1:0]    col_inc;
  logic wrap_pre, flushing, final_tick, drop, in_fire, issue;
  logic [CW-1:0]   cur_col;
  logic [RowW-1:0] cur_row;

  logic              s1_valid;
  logic [CW-1:0]     s1_col;
  logic [RowW-1:0]   s1_row;
  logic [PixW-1:0]   s1_pix;
  logic              s1_fwd;
  logic [2*PixW-1:0] s1_fwd_word;
  logic [2*PixW-1:0] mem_q, rd_word, wr_word;
  logic [PixW-1:0]   col_top, col_mid;

  logic            col_nz;
  logic [WW-1:0]   cc;
  logic [RowW-1:0] cr;
  logic [RowW-1:0] h_last;
  win_ctrl_t       s1_ctrl;

  logic            res_valid, res_last;
  logic [ResW-1:0] res_edges;
  logic [ResW:0]   fifo_out;
  logic [FifoCntW-1:0] fifo_count;
  logic [CrW-1:0]  inflight;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_width  <= WIDTH_RESET;
      reg_height <= HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  reg_width  <= cfg_data[WIDTH_REG_W-1:0];
        REG_IMAGE_HEIGHT: reg_height <= cfg_data[HEIGHT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  assign width_ext = CmpW'(reg_width);

  always_comb begin
    if (reg_width == '0) begin
      w_eff = WW'(1);
    end else if (width_ext > CmpW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(reg_width);
    end
  end

  assign h_eff  = (reg_height == '0) ? ROW_W'(1) : reg_height;
  assign h_last = {1'b0, h_eff} - RowW'(1);

  // Raster position of the incoming beat
  assign wrap_pre = (row_cnt < h_eff) && (WW'(col_cnt) >= w_eff);
  assign col_a    = wrap_pre ? '0 : col_cnt;
  assign row_a    = wrap_pre ? row_cnt + 1'b1 : row_cnt;
  assign flushing = (row_a >= h_eff);
  assign drop     = !flushing && s_tuser;
  assign final_tick = flushing && (flush_cnt >= w_eff);
  assign in_fire  = s_tvalid && s_tready;
  assign issue    = in_fire && !drop;
  assign col_inc  = WW'(col_a) + WW'(1);

  always_comb begin
    if (!flushing) begin
      cur_col = col_a;
      cur_row = {1'b0, row_a};
    end else if (!final_tick) begin
      cur_col = flush_cnt[CW-1:0];
      cur_row = {1'b0, h_eff};
    end else begin
      cur_col = '0;
      cur_row = {1'b0, h_eff} + RowW'(1);
    end
  end

  always_comb begin
    col_next   = col_a;
    row_next   = row_a;
    flush_next = flush_cnt;
    if (!drop) begin
      if (!flushing) begin
        if (col_inc >= w_eff) begin
          col_next = '0;
          row_next = row_a + 1'b1;
        end else begin
          col_next = col_inc[CW-1:0];
        end
      end else if (final_tick) begin
        col_next   = '0;
        row_next   = '0;
        flush_next = '0;
      end else begin
        flush_next = flush_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt   <= '0;
      row_cnt   <= '0;
      flush_cnt <= '0;
    end else if (in_fire) begin
      col_cnt   <= col_next;
      row_cnt   <= row_next;
      flush_cnt <= flush_next;
    end
  end

  // Read stage: the line-buffer read is issued with each accepted beat that is not dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_col      <= cur_col;
      s1_row      <= cur_row;
      s1_pix      <= flushing ? '0 : s_tdata[PixW-1:0];
      // the column still being written this cycle reads stale data: take the write
      s1_fwd      <= s1_valid && (s1_col == cur_col);
      s1_fwd_word <= wr_word;
    end
  end

  sef_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW),
    .DW    (2 * PixW)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (issue),
    .rd_addr (cur_col),
    .rd_data (mem_q),
    .wr_en   (s1_valid),
    .wr_addr (s1_col),
    .wr_data (wr_word)
  );

  // word layout: older row in the low half, newer row in the high half
  assign rd_word = s1_fwd ? s1_fwd_word : mem_q;
  assign col_top = rd_word[PixW-1:0];
  assign col_mid = rd_word[2*PixW-1:PixW];
  assign wr_word = {s1_pix, col_mid};

  // Center pixel of the window after this shift and its border masks
  assign col_nz = (s1_col != '0);
  assign cc     = col_nz ? WW'(s1_col) - WW'(1) : w_eff - WW'(1);
  assign cr     = col_nz ? s1_row - RowW'(1) : s1_row - RowW'(2);

  always_comb begin
    s1_ctrl.emit      = col_nz ? (s1_row >= RowW'(1)) : (s1_row >= RowW'(2));
    s1_ctrl.col_lo_ok = (cc != '0);
    s1_ctrl.col_hi_ok = (cc < w_eff - WW'(1));
    s1_ctrl.row_lo_ok = (cr != '0);
    s1_ctrl.row_hi_ok = (cr < h_last);
    s1_ctrl.last      = (cr == h_last) && (cc == w_eff - WW'(1));
  end

  sef_window #(
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_window (
    .clk       (clk),
    .rst       (rst),
    .shift     (s1_valid),
    .col_top   (col_top),
    .col_mid   (col_mid),
    .col_new   (s1_pix),
    .ctrl      (s1_ctrl),
    .res_valid (res_valid),
    .res_edges (res_edges),
    .res_last  (res_last)
  );

  sef_out_fifo #(
    .DEPTH (FifoDepth),
    .DW    (ResW + 1)
  ) u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (res_valid),
    .in_data   ({res_last, res_edges}),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (fifo_out),
    .count     (fifo_count)
  );

  assign m_tdata = OutDataW'(fifo_out[ResW-1:0]);
  assign m_tlast = fifo_out[ResW];

  // Hold input while queued plus in-flight beats could fill the output queue
  assign inflight = CrW'(fifo_count) + CrW'(s1_valid) + CrW'(res_valid);
  assign s_tready = (inflight < CrW'(FifoDepth));

  assert property (@(posedge clk) disable iff (rst) inflight <= CrW'(FifoDepth))
    else $error("output queue credit exceeded");

  assert property (@(posedge clk) disable iff (rst)
    s1_valid && $past(s1_valid) && ($past(s1_col) == s1_col) |-> s1_fwd)
    else $error("same-column back-to-back read not forwarded");

  assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_fwd |-> $past(s1_valid) && ($past(s1_col) == s1_col))
    else $error("forwarding applied without a colliding write");

  assert property (@(posedge clk) disable iff (rst) in_fire && drop |=> !s1_valid)
    else $error("dropped beat entered the pipeline");

endmodule
